FILE: hw/rtl/sscs_pkg.sv
package sscs_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DevW    = 3;
  localparam int unsigned NumberW = 16;
  localparam int unsigned RemW    = 14;  // holds 0..9999
  localparam int unsigned DigitW  = 4;
  localparam int unsigned StepW   = 3;   // up to eight bytes per run
  localparam int unsigned CfgIdxW = 3;

  localparam logic [RemW-1:0] MaxDisplay = 14'd9999;

  localparam logic [ByteW-1:0] ClearCmdReset     = 8'd118;
  localparam logic [ByteW-1:0] BrightCmdReset    = 8'd122;
  localparam logic [ByteW-1:0] ThousandsCmdReset = 8'd123;
  localparam logic [ByteW-1:0] HundredsCmdReset  = 8'd124;
  localparam logic [ByteW-1:0] TensCmdReset      = 8'd125;
  localparam logic [ByteW-1:0] UnitsCmdReset     = 8'd126;

  localparam logic [StepW-1:0] LastNumberStep = 3'd7;

  typedef enum logic [1:0] {
    OP_SHOW_NUMBER = 2'd0,
    OP_CLEAR       = 2'd1,
    OP_BRIGHTNESS  = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLEAR_CMD     = 3'd0,
    REG_BRIGHT_CMD    = 3'd1,
    REG_THOUSANDS_CMD = 3'd2,
    REG_HUNDREDS_CMD  = 3'd3,
    REG_TENS_CMD      = 3'd4,
    REG_UNITS_CMD     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [NumberW-1:0] number;
    logic [ByteW-1:0]   brightness;
    logic [DevW-1:0]    device_select;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] spi_byte;
    logic [DevW-1:0]  target_device;
    logic             last_byte;
  } out_item_t;

  // Index 0 of digit_cmd is the thousands position, 3 the units position.
  typedef struct packed {
    logic [ByteW-1:0]        clear_cmd;
    logic [ByteW-1:0]        bright_cmd;
    logic [3:0][ByteW-1:0]   digit_cmd;
  } cfg_t;

  function automatic logic [RemW-1:0] place_scale(input logic [1:0] pos);
    logic [RemW-1:0] scale;
    case (pos)
      2'd0:    scale = 14'd1000;
      2'd1:    scale = 14'd100;
      2'd2:    scale = 14'd10;
      default: scale = 14'd1;
    endcase
    return scale;
  endfunction

  function automatic logic [ByteW-1:0] seg_pattern(input logic [DigitW-1:0] digit);
    logic [ByteW-1:0] pat;
    case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

FILE: hw/rtl/sscs_cfg_regs.sv
module sscs_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sscs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sscs_pkg::ByteW-1:0]       cfg_wdata_i,
  output sscs_pkg::cfg_t                   cfg_o
);

  sscs_pkg::cfg_t cfg_q;

  // Indexes beyond the register list drop the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clear_cmd    <= sscs_pkg::ClearCmdReset;
      cfg_q.bright_cmd   <= sscs_pkg::BrightCmdReset;
      cfg_q.digit_cmd[0] <= sscs_pkg::ThousandsCmdReset;
      cfg_q.digit_cmd[1] <= sscs_pkg::HundredsCmdReset;
      cfg_q.digit_cmd[2] <= sscs_pkg::TensCmdReset;
      cfg_q.digit_cmd[3] <= sscs_pkg::UnitsCmdReset;
    end else if (cfg_we_i) begin
      case (sscs_pkg::reg_idx_e'(cfg_idx_i))
        sscs_pkg::REG_CLEAR_CMD:     cfg_q.clear_cmd    <= cfg_wdata_i;
        sscs_pkg::REG_BRIGHT_CMD:    cfg_q.bright_cmd   <= cfg_wdata_i;
        sscs_pkg::REG_THOUSANDS_CMD: cfg_q.digit_cmd[0] <= cfg_wdata_i;
        sscs_pkg::REG_HUNDREDS_CMD:  cfg_q.digit_cmd[1] <= cfg_wdata_i;
        sscs_pkg::REG_TENS_CMD:      cfg_q.digit_cmd[2] <= cfg_wdata_i;
        sscs_pkg::REG_UNITS_CMD:     cfg_q.digit_cmd[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/sscs_digit_step.sv
module sscs_digit_step (
  input  logic [sscs_pkg::RemW-1:0]   rem_i,
  input  logic [1:0]                  pos_i,
  output logic [sscs_pkg::DigitW-1:0] digit_o,
  output logic [sscs_pkg::RemW-1:0]   rem_o
);

  logic [sscs_pkg::RemW-1:0] scale;
  logic [sscs_pkg::RemW-1:0] weight;

  assign scale = sscs_pkg::place_scale(pos_i);

  // Compare against every multiple of the place value; the largest one that
  // fits gives the digit and the remainder.
  always_comb begin
    digit_o = '0;
    rem_o   = rem_i;
    weight  = '0;
    for (int k = 1; k < 10; k++) begin
      weight = sscs_pkg::RemW'(scale * 4'(k));
      if (rem_i >= weight) begin
        digit_o = sscs_pkg::DigitW'(k);
        rem_o   = rem_i - weight;
      end
    end
  end

endmodule

FILE: hw/rtl/seven_segment_command_serializer_unit.sv
// Seven-segment display command serializer.
// Input channel: in_valid_i / in_stall_o / in_data_i carry one request beat
// (operation, number, brightness, device_select). Output channel:
// out_valid_o / out_stall_i / out_data_o carry one byte beat tagged with the
// target device and a last-byte mark. A beat moves when valid is high and
// stall is low.
// Show number yields 8 beats (position command, segment pattern, for each of
// thousands, hundreds, tens, units; values above 9999 show 9999). Clear
// yields 1 beat, brightness 2 beats. Operation code 3 yields nothing.
// Path: an accepted request is held in the item register, and each of its
// bytes then passes to the output register. Throughput: one output beat per
// cycle while out_stall_i is low; a request occupies the item register until
// its last byte moves into the output register, and the next request is taken
// in that same cycle, so runs follow each other with no gap.
// Each digit is found by a compare-and-subtract unit while its position
// command byte goes out.
// Stall: the output register holds its beat and the item register holds;
// the input stalls once the item register is busy.
// Reset: no beats in flight, command registers back to their defaults.
// Configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i; write only while idle.
module seven_segment_command_serializer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sscs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sscs_pkg::ByteW-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sscs_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sscs_pkg::out_item_t            out_data_o
);

  sscs_pkg::cfg_t cfg;

  // Item register: control part
  logic                         busy_q, busy_d;
  logic [sscs_pkg::StepW-1:0]   step_q;
  // Item register: payload part
  logic [1:0]                   op_q;
  logic [sscs_pkg::RemW-1:0]    rem_q, rem_d;
  logic [sscs_pkg::ByteW-1:0]   bri_q;
  logic [sscs_pkg::DevW-1:0]    dev_q;
  logic [sscs_pkg::DigitW-1:0]  dig_q, dig_d;

  // Output register
  logic                         out_valid_q;
  sscs_pkg::out_item_t          out_q;

  logic                         load_en;
  logic                         emit;
  logic                         in_accept;
  logic [sscs_pkg::ByteW-1:0]   byte_sel;
  logic                         last_sel;
  logic [sscs_pkg::RemW-1:0]    in_rem;
  logic [sscs_pkg::DigitW-1:0]  step_digit;
  logic [sscs_pkg::RemW-1:0]    step_rem;

  sscs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sscs_digit_step u_digit_step (
    .rem_i   (rem_q),
    .pos_i   (step_q[2:1]),
    .digit_o (step_digit),
    .rem_o   (step_rem)
  );

  // The output register takes a new beat when empty or when its beat leaves.
  assign load_en = !out_valid_q || !out_stall_i;
  assign emit    = busy_q && load_en;

  // Pick the byte for the current step of the run.
  always_comb begin
    byte_sel = '0;
    last_sel = 1'b1;
    case (sscs_pkg::op_e'(op_q))
      sscs_pkg::OP_SHOW_NUMBER: begin
        // even steps: position command; odd steps: pattern of the digit found
        if (!step_q[0]) begin
          byte_sel = cfg.digit_cmd[step_q[2:1]];
        end else begin
          byte_sel = sscs_pkg::seg_pattern(dig_q);
        end
        last_sel = (step_q == sscs_pkg::LastNumberStep);
      end
      sscs_pkg::OP_CLEAR: begin
        byte_sel = cfg.clear_cmd;
        last_sel = 1'b1;
      end
      sscs_pkg::OP_BRIGHTNESS: begin
        byte_sel = step_q[0] ? bri_q : cfg.bright_cmd;
        last_sel = step_q[0];
      end
      default: begin
        byte_sel = '0;
        last_sel = 1'b1;
      end
    endcase
  end

  // Take a new request once the current run has handed over its last byte.
  assign in_stall_o = busy_q && !(emit && last_sel);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_rem = (in_data_i.number > sscs_pkg::NumberW'(sscs_pkg::MaxDisplay))
                ? sscs_pkg::MaxDisplay
                : in_data_i.number[sscs_pkg::RemW-1:0];

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    dig_d  = dig_q;
    if (in_accept) begin
      // an unused operation code produces no run
      busy_d = (in_data_i.operation != sscs_pkg::OP_SHOW_NUMBER) &&
               (in_data_i.operation != sscs_pkg::OP_CLEAR) &&
               (in_data_i.operation != sscs_pkg::OP_BRIGHTNESS) ? 1'b0 : 1'b1;
      rem_d  = in_rem;
    end else if (emit) begin
      busy_d = !last_sel;
      if ((sscs_pkg::op_e'(op_q) == sscs_pkg::OP_SHOW_NUMBER) && !step_q[0]) begin
        dig_d = step_digit;
        rem_d = step_rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (in_accept) begin
        step_q <= '0;
      end else if (emit) begin
        step_q <= sscs_pkg::StepW'(step_q + 1'b1);
      end
      if (load_en) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dig_q <= dig_d;
    if (in_accept) begin
      op_q  <= in_data_i.operation;
      bri_q <= in_data_i.brightness;
      dev_q <= in_data_i.device_select;
    end
    if (emit) begin
      out_q.spi_byte      <= byte_sel;
      out_q.target_device <= dev_q;
      out_q.last_byte     <= last_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: bench/sscs_display_check_pkg.sv
package sscs_display_check_pkg;
  import sscs_pkg::*;

  // Operation code with no meaning: the block drops it.
  localparam logic [1:0] OpUnused = 2'd3;

  // Register indexes past the last command register: writes are dropped.
  localparam logic [CfgIdxW-1:0] RegSpareLow  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHigh = 3'd7;

  localparam int unsigned DisplayCeiling = 9999;
  localparam int unsigned ReportLimit    = 10;

  // Segment glyphs for digits 0..9, bit 0 is segment a.
  localparam logic [ByteW-1:0] DigitGlyph [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  class display_run_board;
    logic [ByteW-1:0] cmd_byte [6];
    out_item_t        pending_bytes [$];
    int unsigned      mismatches;
    int unsigned      requests_noted;
    int unsigned      bytes_checked;

    function new();
      cmd_byte[REG_CLEAR_CMD]     = ClearCmdReset;
      cmd_byte[REG_BRIGHT_CMD]    = BrightCmdReset;
      cmd_byte[REG_THOUSANDS_CMD] = ThousandsCmdReset;
      cmd_byte[REG_HUNDREDS_CMD]  = HundredsCmdReset;
      cmd_byte[REG_TENS_CMD]      = TensCmdReset;
      cmd_byte[REG_UNITS_CMD]     = UnitsCmdReset;
      mismatches     = 0;
      requests_noted = 0;
      bytes_checked  = 0;
    endfunction

    function void write_command(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      if (idx <= REG_UNITS_CMD) begin
        cmd_byte[idx] = val;
      end
    endfunction

    function void queue_byte(logic [ByteW-1:0] b, logic [DevW-1:0] dev, logic last);
      out_item_t beat;
      beat.spi_byte      = b;
      beat.target_device = dev;
      beat.last_byte     = last;
      pending_bytes.push_back(beat);
    endfunction

    // Expand one accepted request into the byte run the display should see.
    function void note_request(in_item_t req);
      int unsigned shown;
      int unsigned digit [4];
      requests_noted++;
      case (req.operation)
        OP_SHOW_NUMBER: begin
          shown    = (32'(req.number) > DisplayCeiling) ? DisplayCeiling : 32'(req.number);
          digit[0] = shown / 1000;
          digit[1] = (shown / 100) % 10;
          digit[2] = (shown / 10) % 10;
          digit[3] = shown % 10;
          for (int k = 0; k < 4; k++) begin
            queue_byte(cmd_byte[REG_THOUSANDS_CMD + k], req.device_select, 1'b0);
            queue_byte(DigitGlyph[digit[k]], req.device_select, k == 3);
          end
        end
        OP_CLEAR: begin
          queue_byte(cmd_byte[REG_CLEAR_CMD], req.device_select, 1'b1);
        end
        OP_BRIGHTNESS: begin
          queue_byte(cmd_byte[REG_BRIGHT_CMD], req.device_select, 1'b0);
          queue_byte(req.brightness, req.device_select, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("byte %0d: none expected, got byte %02h dev %0d last %0d",
                   bytes_checked, got.spi_byte, got.target_device, got.last_byte);
        end
        return;
      end
      want = pending_bytes.pop_front();
      if (got.spi_byte !== want.spi_byte || got.target_device !== want.target_device ||
          got.last_byte !== want.last_byte) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("byte %0d: expected byte %02h dev %0d last %0d, got byte %02h dev %0d last %0d",
                   bytes_checked, want.spi_byte, want.target_device, want.last_byte,
                   got.spi_byte, got.target_device, got.last_byte);
        end
      end
    endfunction
  endclass

endpackage

FILE: bench/tb_seven_segment_command_serializer_unit.sv
module tb_seven_segment_command_serializer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sscs_pkg::*;
  import sscs_display_check_pkg::*;

  localparam int unsigned LongHoldCycles = 160;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned RandomPerPhase = 75;

  typedef enum int unsigned {
    StallNone,
    StallCoin,
    StallSolid,
    StallLight
  } stall_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = REG_CLEAR_CMD;
  logic [ByteW-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;

  display_run_board board;
  bit               hold_off_armed = 1'b0;
  int unsigned      quiet_cycles   = 0;
  int unsigned      settings_used  = 0;

  seven_segment_command_serializer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Snoop both channels and the register port at the rising edge, where the
  // block itself samples them. Inputs only move on the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        board.write_command(cfg_idx_i, cfg_wdata_i);
      end
      if (in_valid_i && !in_stall_o) begin
        board.note_request(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_byte(out_data_o);
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
      $display("tb_seven_segment_command_serializer_unit NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: runs of free flow, coin-flip stalls, solid stalls and light
  // stalls. Once armed, hold off for a long stretch so the item register
  // and the output register both fill and the input stalls.
  initial begin : receiver_pattern
    stall_mode_e mode;
    int unsigned run;
    int unsigned held;
    @(posedge rst_ni);
    forever begin
      if (hold_off_armed) begin
        held = 0;
        while (held < LongHoldCycles) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
          held++;
        end
        hold_off_armed = 1'b0;
      end
      mode = stall_mode_e'($urandom_range(0, 3));
      run  = $urandom_range(1, 30);
      for (int unsigned c = 0; c < run; c++) begin
        @(negedge clk_i);
        case (mode)
          StallNone:  out_stall_i <= 1'b0;
          StallCoin:  out_stall_i <= ($urandom_range(0, 1) == 1);
          StallSolid: out_stall_i <= 1'b1;
          default:    out_stall_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic in_item_t make_request(logic [1:0] op, logic [NumberW-1:0] num,
                                            logic [ByteW-1:0] bri, logic [DevW-1:0] dev);
    in_item_t req;
    req.operation     = op;
    req.number        = num;
    req.brightness    = bri;
    req.device_select = dev;
    return req;
  endfunction

  // Half are numbers, with weight on the saturation edge and on small values;
  // the device select covers all eight codes, six and seven included.
  function automatic in_item_t random_request();
    logic [1:0]         op;
    logic [NumberW-1:0] num;
    int unsigned        pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      op = OP_SHOW_NUMBER;
    end else if (pick < 14) begin
      op = OP_CLEAR;
    end else if (pick < 19) begin
      op = OP_BRIGHTNESS;
    end else begin
      op = OpUnused;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: num = NumberW'($urandom_range(0, 65535));
      8:       num = NumberW'($urandom_range(9990, 10010));
      9:       num = NumberW'($urandom_range(0, 20));
      default: num = NumberW'($urandom_range(0, DisplayCeiling));
    endcase
    return make_request(op, num, ByteW'($urandom_range(0, 255)), DevW'($urandom_range(0, 7)));
  endfunction

  // Offer one request beat and hold it until the block takes it.
  task automatic offer_request(in_item_t req);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  // Drop valid for a few cycles, with junk on the data lines.
  task automatic idle_input(int unsigned cycles);
    for (int unsigned c = 0; c < cycles; c++) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      in_data_i  <= random_request();
    end
  endtask

  // Bursts of random length separated by random gaps; some bursts run
  // straight into the next. Dropped requests do not count toward the total.
  task automatic stream_random(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    in_item_t    req;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int unsigned b = 0; b < burst && sent < count; b++) begin
        req = random_request();
        offer_request(req);
        if (req.operation != OpUnused) begin
          sent++;
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        idle_input($urandom_range(1, 8));
      end
    end
  endtask

  // Drop valid, wait for every predicted byte, then give a dropped request
  // time to leave the block before anything else happens.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending_bytes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  // Load all six command bytes, then poke the two spare indexes last so an
  // aliasing decode would clobber a real register and show up in the bytes.
  task automatic program_commands(logic [ByteW-1:0] clear_b, logic [ByteW-1:0] bright_b,
                                  logic [ByteW-1:0] thou_b, logic [ByteW-1:0] hund_b,
                                  logic [ByteW-1:0] tens_b, logic [ByteW-1:0] units_b,
                                  logic [ByteW-1:0] spare_b);
    write_register(REG_CLEAR_CMD, clear_b);
    write_register(REG_BRIGHT_CMD, bright_b);
    write_register(REG_THOUSANDS_CMD, thou_b);
    write_register(REG_HUNDREDS_CMD, hund_b);
    write_register(REG_TENS_CMD, tens_b);
    write_register(REG_UNITS_CMD, units_b);
    write_register(RegSpareLow, spare_b);
    write_register(RegSpareHigh, ~spare_b);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    board = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass on the reset command bytes: zero, saturation edge and
    // far past it, each digit 0..9 in at least one place, smallest values per
    // position, clear and brightness at the byte extremes, pass-through of
    // device codes six and seven, and the meaningless operation code.
    offer_request(make_request(OP_SHOW_NUMBER, 16'd0, 8'h00, 3'd0));
    offer_request(make_request(OP_SHOW_NUMBER, 16'd9999, 8'hFF, 3'd5));
    offer_request(make_request(OP_SHOW_NUMBER, 16'd10000, 8'h00, 3'd1));
    offer_request(make_request(OP_SHOW_NUMBER, 16'hFFFF, 8'hFF, 3'd7));
    offer_request(make_request(OP_SHOW_NUMBER, 16'd1234, 8'h00, 3'd2));
    offer_request(make_request(OP_SHOW_NUMBER, 16'd5678, 8'h00, 3'd3));
    offer_request(make_request(OP_SHOW_NUMBER, 16'd9012, 8'h00, 3'd4));
    offer_request(make_request(OP_SHOW_NUMBER, 16'd3456, 8'h00, 3'd6));
    offer_request(make_request(OP_SHOW_NUMBER, 16'd7890, 8'h00, 3'd0));
    idle_input(3);
    offer_request(make_request(OP_SHOW_NUMBER, 16'd9, 8'h00, 3'd1));
    offer_request(make_request(OP_SHOW_NUMBER, 16'd10, 8'h00, 3'd2));
    offer_request(make_request(OP_SHOW_NUMBER, 16'd100, 8'h00, 3'd3));
    offer_request(make_request(OP_SHOW_NUMBER, 16'd1000, 8'h00, 3'd4));
    offer_request(make_request(OP_CLEAR, 16'd0, 8'h00, 3'd0));
    offer_request(make_request(OP_CLEAR, 16'hFFFF, 8'hFF, 3'd7));
    offer_request(make_request(OP_BRIGHTNESS, 16'd0, 8'h00, 3'd1));
    offer_request(make_request(OP_BRIGHTNESS, 16'd0, 8'hFF, 3'd6));
    offer_request(make_request(OpUnused, 16'hFFFF, 8'hFF, 3'd7));
    offer_request(make_request(OpUnused, 16'd0, 8'h00, 3'd0));
    offer_request(make_request(OP_BRIGHTNESS, 16'd0, 8'h5A, 3'd5));
    settle_block();

    // All command bytes at zero; arm the long receiver hold-off here so it
    // lands while the sender keeps offering.
    program_commands(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
    hold_off_armed = 1'b1;
    stream_random(RandomPerPhase);
    settle_block();

    // All command bytes at the top of their range.
    program_commands(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    stream_random(RandomPerPhase);
    settle_block();

    // Two random settings.
    repeat (2) begin
      program_commands(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                       ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                       ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                       ByteW'($urandom_range(0, 255)));
      stream_random(RandomPerPhase);
      settle_block();
    end

    if (board.pending_bytes.size() != 0) begin
      board.mismatches += board.pending_bytes.size();
      $display("%0d predicted bytes never arrived", board.pending_bytes.size());
    end
    if (board.mismatches > ReportLimit) begin
      $display("%0d mismatching beats in total", board.mismatches);
    end
    $display("run: %0d requests taken, %0d bytes compared, %0d command settings",
             board.requests_noted, board.bytes_checked, settings_used + 1);
    $display("included one %0d-cycle output hold-off under a live sender", LongHoldCycles);
    if (board.mismatches == 0) begin
      $display("tb_seven_segment_command_serializer_unit OK");
    end else begin
      $display("tb_seven_segment_command_serializer_unit NOT OK");
    end
    $finish;
  end

endmodule
